// ===== rtl/crf_pkg.sv =====
`default_nettype none

package crf_pkg;

	// field widths
	localparam int IDX_W  = 16;
	localparam int LEN_W  = 16;
	localparam int SIM_W  = 14;
	localparam int CNT_W  = 17;
	localparam int REG_W  = 16;
	localparam int SUM_W  = 30;
	localparam int BASE_W = 32;
	localparam int CFG_W  = 16;

	// saturation limits
	localparam logic [CNT_W-1:0]  PAIR_SAT   = CNT_W'(65536);
	localparam logic [CNT_W-1:0]  RUN_SAT    = '1;
	localparam logic [REG_W-1:0]  REGION_SAT = '1;
	localparam logic [SUM_W-1:0]  SUM_SAT    = '1;
	localparam logic [BASE_W-1:0] BASE_SAT   = '1;

	// register reset values
	localparam logic [SIM_W-1:0] THRESHOLD_RESET = SIM_W'(9500);
	localparam logic [CFG_W-1:0] MIN_PAIRS_RESET = CFG_W'(3);

	// register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_MIN_PAIRS = 1'b1;

	// record kinds
	localparam logic REC_REGION = 1'b0;
	localparam logic REC_STATS  = 1'b1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// classified pair
	typedef struct packed {
		logic [IDX_W-1:0] idx1;
		logic [IDX_W-1:0] idx2;
		logic [LEN_W-1:0] len1;
		logic [LEN_W-1:0] len2;
		logic [SIM_W-1:0] sim;
		logic             cons;
		logic             mono;
		logic             last;
	} entry_t;

	// one result record
	typedef struct packed {
		logic              kind;
		logic              last;
		logic [CNT_W-1:0]  word_a;
		logic [CNT_W-1:0]  word_b;
		logic [CNT_W-1:0]  word_c;
		logic [SUM_W-1:0]  sim_total;
		logic [REG_W-1:0]  sim_floor;
		logic [BASE_W-1:0] bases;
		logic [LEN_W-1:0]  shortest;
		logic [LEN_W-1:0]  longest;
	} record_t;

endpackage

`default_nettype wire

// ===== rtl/conserved_run_finder_unit.sv =====
`default_nettype none

// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------------
// input     | in_valid / in_ready       | first_index .. array_end, one pair
// output    | out_valid / out_ready     | record_kind .. longest_monomer
// config    | cfg_write_en              | cfg_index, cfg_data (no read-back)
//
// one pair per cycle sustained while out_ready stays high; a pair that ends an array
// and also closes a reported run gives two transactions; the queue waits on the second.
// a result passes through the input stage, the queue and the output register.
// arst_n clears the run state, counters, queue and valid flags; threshold
// resets to 9500 and minimum run length to 3.
// out_ready low backs up into the four-entry queue; in_ready drops once the
// queue and the input stage are full.

module conserved_run_finder_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write_en,
	input  wire logic                         cfg_index,
	input  wire logic [crf_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [crf_pkg::IDX_W-1:0]    first_index,
	input  wire logic [crf_pkg::IDX_W-1:0]    second_index,
	input  wire logic [crf_pkg::LEN_W-1:0]    first_length,
	input  wire logic [crf_pkg::LEN_W-1:0]    second_length,
	input  wire logic [crf_pkg::SIM_W-1:0]    similarity_pct,
	input  wire logic                         both_monomer,
	input  wire logic                         array_end,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              record_kind,
	output logic                              run_last,
	output logic [crf_pkg::CNT_W-1:0]         word_a,
	output logic [crf_pkg::CNT_W-1:0]         word_b,
	output logic [crf_pkg::CNT_W-1:0]         word_c,
	output logic [crf_pkg::SUM_W-1:0]         similarity_total,
	output logic [crf_pkg::REG_W-1:0]         similarity_floor,
	output logic [crf_pkg::BASE_W-1:0]        base_total,
	output logic [crf_pkg::LEN_W-1:0]         shortest_monomer,
	output logic [crf_pkg::LEN_W-1:0]         longest_monomer
);
	import crf_pkg::*;

	logic [SIM_W-1:0] threshold_q;
	logic [CFG_W-1:0] min_pairs_q;
	entry_t           in_item;
	logic             push_valid;
	logic             push_ready;
	entry_t           push_item;
	logic             pop_valid;
	logic             pop_ready;
	entry_t           pop_item;
	record_t          rec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			min_pairs_q <= MIN_PAIRS_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == CFG_THRESHOLD) begin
				threshold_q <= cfg_data[SIM_W-1:0];
			end
			if (cfg_index == CFG_MIN_PAIRS) begin
				min_pairs_q <= cfg_data;
			end
		end
	end

	// pack the incoming pair
	always_comb begin
		in_item.idx1 = first_index;
		in_item.idx2 = second_index;
		in_item.len1 = first_length;
		in_item.len2 = second_length;
		in_item.sim  = similarity_pct;
		in_item.cons = 1'b0;
		in_item.mono = both_monomer;
		in_item.last = array_end;
	end

	crf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.threshold  (threshold_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	crf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	crf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.min_pairs  (min_pairs_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_rec    (rec)
	);

	// unpack the result record
	assign record_kind      = rec.kind;
	assign run_last         = rec.last;
	assign word_a           = rec.word_a;
	assign word_b           = rec.word_b;
	assign word_c           = rec.word_c;
	assign similarity_total = rec.sim_total;
	assign similarity_floor = rec.sim_floor;
	assign base_total       = rec.bases;
	assign shortest_monomer = rec.shortest;
	assign longest_monomer  = rec.longest;

endmodule

`default_nettype wire

// ===== rtl/crf_front.sv =====
`default_nettype none

module crf_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire crf_pkg::entry_t             in_item,
	input  wire logic [crf_pkg::SIM_W-1:0]   threshold,
	output logic                             push_valid,
	input  wire logic                        push_ready,
	output crf_pkg::entry_t                  push_item
);
	import crf_pkg::*;

	logic   valid_s1;
	entry_t item_s1;
	entry_t classified;
	logic   accept;

	// stage frees up when empty or when the queue takes its item
	assign in_ready   = !valid_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// classify against the threshold
	always_comb begin
		classified      = in_item;
		classified.cons = in_item.sim >= threshold;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= classified;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crf_queue.sv =====
`default_nettype none

module crf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire crf_pkg::entry_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output crf_pkg::entry_t      pop_item
);
	import crf_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crf_back.sv =====
`default_nettype none

module crf_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      pop_valid,
	output logic                           pop_ready,
	input  wire crf_pkg::entry_t           pop_item,
	input  wire logic [crf_pkg::CFG_W-1:0] min_pairs,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output crf_pkg::record_t               out_rec
);
	import crf_pkg::*;

	// run state
	logic              inside_q;
	logic [IDX_W-1:0]  start_q;
	logic [CNT_W-1:0]  pairs_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SIM_W-1:0]  min_q;
	logic [BASE_W-1:0] bases_q;
	logic [LEN_W-1:0]  short_q;
	logic [LEN_W-1:0]  long_q;
	logic [IDX_W-1:0]  prev_idx_q;

	// array counters
	logic [CNT_W-1:0]  seen_q;
	logic [CNT_W-1:0]  cons_seen_q;
	logic [CNT_W-1:0]  mono_seen_q;
	logic [CNT_W-1:0]  cm_seen_q;
	logic [REG_W-1:0]  regions_q;
	logic [CNT_W-1:0]  rpt_q;

	// output side
	logic              out_valid_q;
	record_t           out_rec_q;
	logic              pend_valid_q;
	record_t           pend_rec_q;

	// combinational
	logic              cm;
	logic              slot_free;
	logic              pop;
	logic [IDX_W-1:0]  ext_start;
	logic [CNT_W-1:0]  ext_pairs;
	logic [SUM_W-1:0]  ext_sum;
	logic [SIM_W-1:0]  ext_min;
	logic [BASE_W-1:0] ext_bases;
	logic [LEN_W-1:0]  ext_short;
	logic [LEN_W-1:0]  ext_long;
	logic [SUM_W:0]    sum_wide;
	logic [BASE_W:0]   bases_wide;
	logic              src_inside;
	logic [IDX_W-1:0]  src_start;
	logic [IDX_W-1:0]  src_end;
	logic [CNT_W-1:0]  src_pairs;
	logic [SUM_W-1:0]  src_sum;
	logic [SIM_W-1:0]  src_min;
	logic [BASE_W-1:0] src_bases;
	logic [LEN_W-1:0]  src_short;
	logic [LEN_W-1:0]  src_long;
	logic              src_gate;
	logic              emit_region;
	logic [CNT_W-1:0]  seen_n;
	logic [CNT_W-1:0]  cons_seen_n;
	logic [CNT_W-1:0]  mono_seen_n;
	logic [CNT_W-1:0]  cm_seen_n;
	logic [REG_W-1:0]  regions_n;
	logic [CNT_W:0]    rpt_wide;
	logic [CNT_W-1:0]  rpt_n;
	record_t           region_rec;
	record_t           stats_rec;

	assign cm        = pop_item.cons && pop_item.mono;
	assign slot_free = !out_valid_q || out_ready;
	assign pop_ready = !pend_valid_q && slot_free;
	assign pop       = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;

	// run extended by the current pair
	always_comb begin
		sum_wide   = {1'b0, sum_q} + (SUM_W + 1)'(pop_item.sim);
		bases_wide = {1'b0, bases_q} + (BASE_W + 1)'(pop_item.len2);
		if (!inside_q) begin
			ext_start = pop_item.idx1;
			ext_pairs = CNT_W'(1);
			ext_sum   = SUM_W'(pop_item.sim);
			ext_min   = pop_item.sim;
			ext_bases = BASE_W'(pop_item.len1) + BASE_W'(pop_item.len2);
			ext_short = (pop_item.len1 < pop_item.len2) ? pop_item.len1 : pop_item.len2;
			ext_long  = (pop_item.len1 > pop_item.len2) ? pop_item.len1 : pop_item.len2;
		end else begin
			ext_start = start_q;
			ext_pairs = (pairs_q == RUN_SAT) ? pairs_q : pairs_q + 1'b1;
			ext_sum   = (sum_wide > {1'b0, SUM_SAT}) ? SUM_SAT : sum_wide[SUM_W-1:0];
			ext_min   = (pop_item.sim < min_q) ? pop_item.sim : min_q;
			ext_bases = (bases_wide > {1'b0, BASE_SAT}) ? BASE_SAT : bases_wide[BASE_W-1:0];
			ext_short = (pop_item.len2 < short_q) ? pop_item.len2 : short_q;
			ext_long  = (pop_item.len2 > long_q) ? pop_item.len2 : long_q;
		end
	end

	// run that may close on this pair
	always_comb begin
		if (cm) begin
			src_inside = 1'b1;
			src_start  = ext_start;
			src_end    = pop_item.idx2;
			src_pairs  = ext_pairs;
			src_sum    = ext_sum;
			src_min    = ext_min;
			src_bases  = ext_bases;
			src_short  = ext_short;
			src_long   = ext_long;
			src_gate   = pop_item.last;
		end else begin
			src_inside = inside_q;
			src_start  = start_q;
			src_end    = prev_idx_q;
			src_pairs  = pairs_q;
			src_sum    = sum_q;
			src_min    = min_q;
			src_bases  = bases_q;
			src_short  = short_q;
			src_long   = long_q;
			src_gate   = 1'b1;
		end
		emit_region = src_gate && src_inside && (src_pairs >= CNT_W'(min_pairs));
	end

	// array counters after this pair
	always_comb begin
		seen_n      = (seen_q == PAIR_SAT) ? seen_q : seen_q + 1'b1;
		cons_seen_n = (pop_item.cons && cons_seen_q != PAIR_SAT) ?
			cons_seen_q + 1'b1 : cons_seen_q;
		mono_seen_n = (pop_item.mono && mono_seen_q != PAIR_SAT) ?
			mono_seen_q + 1'b1 : mono_seen_q;
		cm_seen_n   = (cm && cm_seen_q != PAIR_SAT) ? cm_seen_q + 1'b1 : cm_seen_q;
		regions_n   = (emit_region && regions_q != REGION_SAT) ? regions_q + 1'b1 : regions_q;
		rpt_wide    = {1'b0, rpt_q} + {1'b0, src_pairs};
		if (!emit_region) begin
			rpt_n = rpt_q;
		end else if (rpt_wide > {1'b0, PAIR_SAT}) begin
			rpt_n = PAIR_SAT;
		end else begin
			rpt_n = rpt_wide[CNT_W-1:0];
		end
	end

	// result records
	always_comb begin
		region_rec.kind      = REC_REGION;
		region_rec.last      = !pop_item.last;
		region_rec.word_a    = CNT_W'(src_start);
		region_rec.word_b    = CNT_W'(src_end);
		region_rec.word_c    = src_pairs;
		region_rec.sim_total = src_sum;
		region_rec.sim_floor = REG_W'(src_min);
		region_rec.bases     = src_bases;
		region_rec.shortest  = src_short;
		region_rec.longest   = src_long;

		stats_rec.kind       = REC_STATS;
		stats_rec.last       = 1'b1;
		stats_rec.word_a     = seen_n;
		stats_rec.word_b     = cons_seen_n;
		stats_rec.word_c     = mono_seen_n;
		stats_rec.sim_total  = SUM_W'(cm_seen_n);
		stats_rec.sim_floor  = regions_n;
		stats_rec.bases      = BASE_W'(rpt_n);
		stats_rec.shortest   = '0;
		stats_rec.longest    = '0;
	end

	// run and array state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q    <= 1'b0;
			start_q     <= '0;
			pairs_q     <= '0;
			sum_q       <= '0;
			min_q       <= '0;
			bases_q     <= '0;
			short_q     <= '1;
			long_q      <= '0;
			prev_idx_q  <= '0;
			seen_q      <= '0;
			cons_seen_q <= '0;
			mono_seen_q <= '0;
			cm_seen_q   <= '0;
			regions_q   <= '0;
			rpt_q       <= '0;
		end else if (pop) begin
			if (cm && !pop_item.last) begin
				inside_q <= 1'b1;
				start_q  <= ext_start;
				pairs_q  <= ext_pairs;
				sum_q    <= ext_sum;
				min_q    <= ext_min;
				bases_q  <= ext_bases;
				short_q  <= ext_short;
				long_q   <= ext_long;
			end else begin
				inside_q <= 1'b0;
				start_q  <= '0;
				pairs_q  <= '0;
				sum_q    <= '0;
				min_q    <= '0;
				bases_q  <= '0;
				short_q  <= '1;
				long_q   <= '0;
			end
			prev_idx_q <= pop_item.idx2;
			if (pop_item.last) begin
				seen_q      <= '0;
				cons_seen_q <= '0;
				mono_seen_q <= '0;
				cm_seen_q   <= '0;
				regions_q   <= '0;
				rpt_q       <= '0;
			end else begin
				seen_q      <= seen_n;
				cons_seen_q <= cons_seen_n;
				mono_seen_q <= mono_seen_n;
				cm_seen_q   <= cm_seen_n;
				regions_q   <= regions_n;
				rpt_q       <= rpt_n;
			end
		end
	end

	// output and pending valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q && slot_free) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q  <= emit_region || pop_item.last;
			pend_valid_q <= emit_region && pop_item.last;
		end else if (out_ready) begin
			out_valid_q  <= 1'b0;
		end
	end

	// output and pending records
	always_ff @(posedge clk) begin
		if (pend_valid_q && slot_free) begin
			out_rec_q <= pend_rec_q;
		end else if (pop) begin
			out_rec_q  <= emit_region ? region_rec : stats_rec;
			pend_rec_q <= stats_rec;
		end
	end

`ifndef SYNTHESIS
	// a waiting statistics record always sits behind a shown region record
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q && out_rec_q.kind == REC_REGION)
		else $error("pending record without region record in front");

	// a region record that is not last is followed by a pending one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_rec_q.last |-> pend_valid_q)
		else $error("non-last record with nothing pending");

	// an open run holds at least one pair and its shortest length is no more than its longest
	assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> pairs_q != '0 && short_q <= long_q)
		else $error("open run with inconsistent state");

	// array pair and region pair counters never pass their limit
	assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= PAIR_SAT && rpt_q <= PAIR_SAT)
		else $error("pair counter beyond saturation");

	// a shown record stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_rec_q))
		else $error("stalled record changed");
`endif

endmodule

`default_nettype wire

// ===== tb/conserved_run_finder_unit_tb.sv =====
`default_nettype none

module conserved_run_finder_unit_tb;
	import crf_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned PHASE_ITEMS  = 210;

	// one aligned pair as offered to the block
	typedef struct packed {
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] second_idx;
		logic [LEN_W-1:0] first_len;
		logic [LEN_W-1:0] second_len;
		logic [SIM_W-1:0] similarity;
		logic             monomer;
		logic             array_last;
	} pair_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write_en = 1'b0;
	logic              cfg_index = CFG_THRESHOLD;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [IDX_W-1:0]  first_index = '0;
	logic [IDX_W-1:0]  second_index = '0;
	logic [LEN_W-1:0]  first_length = '0;
	logic [LEN_W-1:0]  second_length = '0;
	logic [SIM_W-1:0]  similarity_pct = '0;
	logic              both_monomer = 1'b0;
	logic              array_end = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              record_kind;
	logic              run_last;
	logic [CNT_W-1:0]  word_a;
	logic [CNT_W-1:0]  word_b;
	logic [CNT_W-1:0]  word_c;
	logic [SUM_W-1:0]  similarity_total;
	logic [REG_W-1:0]  similarity_floor;
	logic [BASE_W-1:0] base_total;
	logic [LEN_W-1:0]  shortest_monomer;
	logic [LEN_W-1:0]  longest_monomer;

	conserved_run_finder_unit u_top (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run finder state as the testbench tracks it
	logic [SIM_W-1:0]  sim_threshold   = THRESHOLD_RESET;
	logic [CFG_W-1:0]  min_pairs       = MIN_PAIRS_RESET;
	logic              run_open        = 1'b0;
	logic [IDX_W-1:0]  run_first       = '0;
	logic [CNT_W-1:0]  run_count       = '0;
	logic [SUM_W-1:0]  run_sum         = '0;
	logic [SIM_W-1:0]  run_min         = '0;
	logic [BASE_W-1:0] run_bases       = '0;
	logic [LEN_W-1:0]  run_shortest    = '1;
	logic [LEN_W-1:0]  run_longest     = '0;
	logic [IDX_W-1:0]  prev_second     = '0;
	logic [CNT_W-1:0]  pairs_count     = '0;
	logic [CNT_W-1:0]  conserved_count = '0;
	logic [CNT_W-1:0]  monomer_count   = '0;
	logic [CNT_W-1:0]  cons_mono_count = '0;
	logic [REG_W-1:0]  regions_count   = '0;
	logic [CNT_W-1:0]  region_pairs    = '0;

	pair_t       pending_pairs[$];
	record_t     fresh_records[$];
	record_t     expected_records[$];
	pair_t       driven_pair;
	int unsigned pairs_queued = 0;
	int unsigned pairs_accepted = 0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;

	function automatic longint unsigned capped_sum(longint unsigned a, longint unsigned b,
			longint unsigned cap);
		return (a + b > cap) ? cap : a + b;
	endfunction

	// end the open run, reporting it as a region when long enough
	function automatic void close_open_run(logic [IDX_W-1:0] end_idx);
		record_t rec;
		if (run_open && run_count >= CNT_W'(min_pairs)) begin
			rec = '0;
			rec.kind      = REC_REGION;
			rec.word_a    = CNT_W'(run_first);
			rec.word_b    = CNT_W'(end_idx);
			rec.word_c    = run_count;
			rec.sim_total = run_sum;
			rec.sim_floor = REG_W'(run_min);
			rec.bases     = run_bases;
			rec.shortest  = run_shortest;
			rec.longest   = run_longest;
			fresh_records.push_back(rec);
			regions_count = REG_W'(capped_sum(regions_count, 1, REGION_SAT));
			region_pairs  = CNT_W'(capped_sum(region_pairs, run_count, PAIR_SAT));
		end
		run_open     = 1'b0;
		run_first    = '0;
		run_count    = '0;
		run_sum      = '0;
		run_min      = '0;
		run_bases    = '0;
		run_shortest = '1;
		run_longest  = '0;
	endfunction

	// advance the tracked state by one accepted pair and queue its records
	function automatic void track_pair(pair_t p);
		record_t rec;
		logic    conserved;
		conserved = p.similarity >= sim_threshold;
		pairs_count = CNT_W'(capped_sum(pairs_count, 1, PAIR_SAT));
		if (conserved)
			conserved_count = CNT_W'(capped_sum(conserved_count, 1, PAIR_SAT));
		if (p.monomer) begin
			monomer_count = CNT_W'(capped_sum(monomer_count, 1, PAIR_SAT));
			if (conserved)
				cons_mono_count = CNT_W'(capped_sum(cons_mono_count, 1, PAIR_SAT));
		end

		if (conserved && p.monomer) begin
			if (!run_open) begin
				run_open     = 1'b1;
				run_first    = p.first_idx;
				run_count    = CNT_W'(1);
				run_sum      = SUM_W'(p.similarity);
				run_min      = p.similarity;
				run_bases    = BASE_W'(p.first_len) + BASE_W'(p.second_len);
				run_shortest = (p.first_len < p.second_len) ? p.first_len : p.second_len;
				run_longest  = (p.first_len > p.second_len) ? p.first_len : p.second_len;
			end else begin
				run_count = CNT_W'(capped_sum(run_count, 1, RUN_SAT));
				run_sum   = SUM_W'(capped_sum(run_sum, p.similarity, SUM_SAT));
				run_bases = BASE_W'(capped_sum(run_bases, p.second_len, BASE_SAT));
				if (p.similarity < run_min)
					run_min = p.similarity;
				if (p.second_len < run_shortest)
					run_shortest = p.second_len;
				if (p.second_len > run_longest)
					run_longest = p.second_len;
			end
		end else begin
			close_open_run(prev_second);
		end
		prev_second = p.second_idx;

		// array end: close the run, then report and clear the array counts
		if (p.array_last) begin
			close_open_run(p.second_idx);
			rec = '0;
			rec.kind      = REC_STATS;
			rec.word_a    = pairs_count;
			rec.word_b    = conserved_count;
			rec.word_c    = monomer_count;
			rec.sim_total = SUM_W'(cons_mono_count);
			rec.sim_floor = regions_count;
			rec.bases     = BASE_W'(region_pairs);
			fresh_records.push_back(rec);
			pairs_count     = '0;
			conserved_count = '0;
			monomer_count   = '0;
			cons_mono_count = '0;
			regions_count   = '0;
			region_pairs    = '0;
		end

		// flag the last record of this pair
		if (fresh_records.size() != 0) begin
			rec = fresh_records.pop_back();
			rec.last = 1'b1;
			fresh_records.push_back(rec);
			while (fresh_records.size() != 0)
				expected_records.push_back(fresh_records.pop_front());
		end
	endfunction

	// idle lengths: mostly short, a few long
	function automatic int unsigned pick_delay();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		if ($urandom_range(0, 9) == 0)
			return LEN_W'($urandom);
		return LEN_W'($urandom_range(120, 220));
	endfunction

	// similarity near the threshold on the wanted side of it
	function automatic logic [SIM_W-1:0] pick_similarity(bit conserved);
		int unsigned thr;
		int unsigned room;
		int unsigned v;
		thr = sim_threshold;
		if (conserved || thr == 0) begin
			room = 16383 - thr;
			if ($urandom_range(0, 4) == 0)
				v = $urandom_range(thr, 16383);
			else
				v = thr + $urandom_range(0, (room < 150) ? room : 150);
		end else begin
			room = thr - 1;
			if ($urandom_range(0, 4) == 0)
				v = $urandom_range(0, room);
			else
				v = room - $urandom_range(0, (room < 150) ? room : 150);
		end
		return SIM_W'(v);
	endfunction

	function automatic void queue_pair(logic [IDX_W-1:0] idx1, logic [IDX_W-1:0] idx2,
			logic [LEN_W-1:0] len1, logic [LEN_W-1:0] len2, logic [SIM_W-1:0] sim,
			logic mono, logic end_flag);
		pair_t p;
		p.first_idx  = idx1;
		p.second_idx = idx2;
		p.first_len  = len1;
		p.second_len = len2;
		p.similarity = sim;
		p.monomer    = mono;
		p.array_last = end_flag;
		pending_pairs.push_back(p);
		pairs_queued++;
	endfunction

	// mostly well-formed arrays of consecutive pairs, some loose noise
	task automatic queue_random_items(int unsigned count);
		int unsigned made;
		int unsigned span;
		logic [IDX_W-1:0] base;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 4) == 0) begin
				queue_pair(IDX_W'($urandom), IDX_W'($urandom), LEN_W'($urandom),
					LEN_W'($urandom), SIM_W'($urandom_range(0, 16383)),
					1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
				made++;
			end else begin
				span = $urandom_range(1, 24);
				base = IDX_W'($urandom);
				for (int unsigned j = 0; j < span; j++)
					queue_pair(IDX_W'(base + j), IDX_W'(base + j + 1), pick_length(),
						pick_length(), pick_similarity($urandom_range(0, 3) != 0),
						$urandom_range(0, 9) != 0, j == span - 1);
				made += span;
			end
		end
	endtask

	task automatic write_reg(logic reg_index, logic [CFG_W-1:0] value);
		if (reg_index == CFG_THRESHOLD)
			sim_threshold = value[SIM_W-1:0];
		else
			min_pairs = value;
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= reg_index;
		cfg_data     <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// wait until every pair is taken and every record is back, then let the pipe drain
	task automatic wait_idle();
		while (pairs_accepted != pairs_queued || expected_records.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endtask

	// pair driver
	int unsigned gap_left = 0;
	int unsigned gap_mode_left = 0;
	bit          gaps_mode = 1'b0;

	always @(posedge clk or negedge arst_n) begin : pair_driver
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_pair(driven_pair);
				pairs_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_pairs.size() != 0) begin
					driven_pair = pending_pairs.pop_front();
					first_index    <= driven_pair.first_idx;
					second_index   <= driven_pair.second_idx;
					first_length   <= driven_pair.first_len;
					second_length  <= driven_pair.second_len;
					similarity_pct <= driven_pair.similarity;
					both_monomer   <= driven_pair.monomer;
					array_end      <= driven_pair.array_last;
					in_valid       <= 1'b1;
					// alternate stretches with and without gaps
					if (gap_mode_left == 0) begin
						gaps_mode     = $urandom_range(0, 3) != 0;
						gap_mode_left = $urandom_range(10, 60);
					end else begin
						gap_mode_left--;
					end
					gap_left = gaps_mode ? pick_delay() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// record monitor and receiver stalls
	int unsigned stall_left = 0;
	int unsigned stall_mode_left = 0;
	bit          stalls_mode = 1'b0;

	always @(posedge clk or negedge arst_n) begin : record_monitor
		record_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_records.size() == 0) begin
					$error("record with no transaction pending: kind %0d, word_a %0d",
						record_kind, word_a);
					fault_count++;
				end else begin
					want = expected_records.pop_front();
					check_field("record_kind", want.kind, record_kind);
					check_field("run_last", want.last, run_last);
					check_field("word_a", want.word_a, word_a);
					check_field("word_b", want.word_b, word_b);
					check_field("word_c", want.word_c, word_c);
					check_field("similarity_total", want.sim_total, similarity_total);
					check_field("similarity_floor", want.sim_floor, similarity_floor);
					check_field("base_total", want.bases, base_total);
					check_field("shortest_monomer", want.shortest, shortest_monomer);
					check_field("longest_monomer", want.longest, longest_monomer);
				end
			end
			if (stall_mode_left == 0) begin
				stalls_mode     = $urandom_range(0, 3) != 0;
				stall_mode_left = $urandom_range(20, 150);
			end else begin
				stall_mode_left--;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (stalls_mode && $urandom_range(0, 4) == 0) begin
				stall_left = pick_delay();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed pairs at reset settings: threshold 9500, at least three pairs per region
		queue_pair(16'd0, 16'd65535, 16'd0, 16'd65535, 14'd9500, 1'b1, 1'b0);
		queue_pair(16'd1, 16'd2, 16'd65535, 16'd0, 14'd10000, 1'b1, 1'b0);
		queue_pair(16'd2, 16'd3, 16'd170, 16'd171, 14'd16383, 1'b1, 1'b0);
		// just under threshold breaks a run of three
		queue_pair(16'd3, 16'd4, 16'd171, 16'd172, 14'd9499, 1'b1, 1'b0);
		queue_pair(16'd4, 16'd5, 16'd170, 16'd170, 14'd9600, 1'b1, 1'b0);
		queue_pair(16'd5, 16'd6, 16'd170, 16'd170, 14'd9700, 1'b1, 1'b0);
		// conserved but not monomers: short run dropped
		queue_pair(16'd6, 16'd7, 16'd170, 16'd170, 14'd9900, 1'b0, 1'b0);
		// run still open at array end
		queue_pair(16'd7, 16'd8, 16'd180, 16'd160, 14'd9800, 1'b1, 1'b0);
		queue_pair(16'd8, 16'd9, 16'd190, 16'd150, 14'd9550, 1'b1, 1'b0);
		queue_pair(16'd9, 16'd10, 16'd200, 16'd140, 14'd9990, 1'b1, 1'b1);
		// array end with no run
		queue_pair(16'd10, 16'd11, 16'd170, 16'd170, 14'd0, 1'b0, 1'b1);
		queue_pair(16'd65535, 16'd0, 16'd65535, 16'd65535, 14'd16383, 1'b1, 1'b0);
		queue_pair(16'd0, 16'd1, 16'd65535, 16'd65535, 14'd16383, 1'b1, 1'b0);
		queue_pair(16'd1, 16'd2, 16'd0, 16'd0, 14'd9500, 1'b1, 1'b1);
		// single pair run at array end is too short
		queue_pair(16'd2, 16'd3, 16'd100, 16'd200, 14'd9500, 1'b1, 1'b1);
		queue_pair(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 14'h2AAA, 1'b1, 1'b0);
		queue_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 14'h1555, 1'b0, 1'b0);
		wait_idle();

		// random phases over a spread of settings
		write_reg(CFG_THRESHOLD, 16'd0);
		write_reg(CFG_MIN_PAIRS, 16'd0);
		queue_random_items(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_THRESHOLD, 16'd10000);
		write_reg(CFG_MIN_PAIRS, 16'd1);
		queue_random_items(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_THRESHOLD, 16'hFFFF);
		write_reg(CFG_MIN_PAIRS, 16'd65535);
		queue_random_items(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_THRESHOLD, CFG_W'($urandom_range(8000, 9999)));
		write_reg(CFG_MIN_PAIRS, CFG_W'($urandom_range(2, 6)));
		queue_random_items(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_THRESHOLD, 16'd9500);
		write_reg(CFG_MIN_PAIRS, 16'd3);
		queue_random_items(PHASE_ITEMS);
		wait_idle();

		if (fault_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/crf_pkg.sv
rtl/crf_front.sv
rtl/crf_queue.sv
rtl/crf_back.sv
rtl/conserved_run_finder_unit.sv
tb/conserved_run_finder_unit_tb.sv
